// ===== hdl/sorted_priority_queue_top_defines.svh =====
// Assertion macros for the sorted priority queue top level.
// Standalone: expects clk and rst_n in the scope where a macro is used.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the sorted priority queue. No dependencies.
package spq_pkg;

    localparam int DEPTH   = 128;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_W   = 8;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int VAL_W   = 32;
    localparam int PRI_W   = 16;
    localparam int FILL_W  = 8;
    localparam int ENTRY_W = VAL_W + PRI_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    typedef enum logic [1:0] {
        CMD_INSERT      = 2'd0,
        CMD_POP_HIGH    = 2'd1,
        CMD_POP_EXACT   = 2'd2,
        CMD_POP_ATLEAST = 2'd3
    } spq_cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOMATCH = 2'd3
    } spq_status_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [PRI_W-1:0]        prio;
    } spq_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS_CMP,
        S_INS_PUT,
        S_SCAN,
        S_DONE
    } spq_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic start;
        logic ins_step;
        logic ins_put;
        logic scan_step;
        logic out_load;
    } spq_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_insert;
        logic full;
        logic empty;
        logic ins_shift;
        logic ins_last;
        logic scan_last;
    } spq_stat_t;

endpackage

// ===== hdl/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
    parameter int DATA_W     = 8,
    parameter int ADDR_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(ADDR_DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]             wdata,
    input  logic [$clog2(ADDR_DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]             rdata
);

    logic [DATA_W-1:0] mem [ADDR_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/spq_datapath.sv =====
// Datapath: entry store, fill count, capacity register, scan index and result registers.
// Depends on spq_pkg and spq_ram.
module spq_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spq_pkg::spq_ctrl_t              ctrl,
    output spq_pkg::spq_stat_t              stat,
    input  logic [1:0]                      cmd,
    input  logic signed [spq_pkg::VAL_W-1:0] item_value,
    input  logic [spq_pkg::PRI_W-1:0]       item_priority,
    input  logic                            cfg_we,
    input  logic [spq_pkg::CAP_W-1:0]       cfg_wdata,
    output logic signed [spq_pkg::VAL_W-1:0] out_value,
    output logic [spq_pkg::PRI_W-1:0]       out_priority,
    output logic [1:0]                      status,
    output logic [spq_pkg::FILL_W-1:0]      fill_count
);
    import spq_pkg::*;

    logic [CAP_W-1:0]        cap_reg, cap_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    found_reg, found_next;
    spq_cmd_t                item_cmd_reg;
    spq_entry_t              item_entry_reg;
    logic signed [VAL_W-1:0] res_value_reg, res_value_next;
    logic [PRI_W-1:0]        res_prio_reg, res_prio_next;
    spq_status_t             res_status_reg, res_status_next;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [PRI_W-1:0]        out_prio_reg;
    spq_status_t             out_status_reg;
    logic [FILL_W-1:0]       out_fill_reg;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [IDX_W-1:0]        ram_raddr;
    spq_entry_t              ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    spq_entry_t              rd_entry;
    logic                    hit;
    logic [CMP_W-1:0]        count_ext;

    spq_ram #(
        .DATA_W     (ENTRY_W),
        .ADDR_DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = spq_entry_t'(ram_rdata);
    assign count_ext = CMP_W'(count_reg);

    always_comb
    begin
        case (item_cmd_reg)
            CMD_POP_HIGH:    hit = 1'b1;
            CMD_POP_EXACT:   hit = (rd_entry.prio == item_entry_reg.prio);
            CMD_POP_ATLEAST: hit = (rd_entry.prio >= item_entry_reg.prio);
            default:         hit = 1'b0;
        endcase
    end

    always_comb
    begin
        stat.is_insert = (item_cmd_reg == CMD_INSERT);
        stat.full      = (count_ext >= CMP_W'(cap_reg)) || (count_reg >= CNT_W'(DEPTH));
        stat.empty     = (count_reg == '0);
        stat.ins_shift = (rd_entry.prio < item_entry_reg.prio);
        stat.ins_last  = (idx_reg == IDX_W'(1));
        stat.scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    end

    // Store access: one write and one read per cycle
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = rd_entry;
        ram_raddr = '0;
        if (ctrl.start && stat.is_insert)
        begin
            ram_raddr = IDX_W'(count_reg - CNT_W'(1));
        end
        if (ctrl.ins_step)
        begin
            ram_raddr = idx_reg - IDX_W'(2);
            ram_we    = 1'b1;
            ram_wdata = stat.ins_shift ? rd_entry : item_entry_reg;
        end
        if (ctrl.ins_put)
        begin
            ram_we    = 1'b1;
            ram_wdata = item_entry_reg;
        end
        if (ctrl.scan_step)
        begin
            ram_raddr = idx_reg + IDX_W'(1);
            ram_we    = found_reg;
            ram_waddr = idx_reg - IDX_W'(1);
        end
    end

    always_comb
    begin
        cap_next        = cfg_we ? cfg_wdata : cap_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        res_value_next  = res_value_reg;
        res_prio_next   = res_prio_reg;
        res_status_next = res_status_reg;
        if (ctrl.start)
        begin
            idx_next        = stat.is_insert ? IDX_W'(count_reg) : '0;
            found_next      = 1'b0;
            res_value_next  = '0;
            res_prio_next   = '0;
            res_status_next = ST_OK;
            if (stat.is_insert && stat.full)
            begin
                res_status_next = ST_FULL;
            end
            else if (!stat.is_insert && stat.empty)
            begin
                res_status_next = ST_EMPTY;
            end
        end
        if (ctrl.ins_step)
        begin
            if (stat.ins_shift)
            begin
                idx_next = idx_reg - IDX_W'(1);
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (ctrl.ins_put)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (ctrl.scan_step)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (!found_reg && hit)
            begin
                found_next     = 1'b1;
                res_value_next = rd_entry.value;
                res_prio_next  = rd_entry.prio;
            end
            if (stat.scan_last)
            begin
                if (found_reg || hit)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    res_status_next = ST_NOMATCH;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            cap_reg   <= cap_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            item_cmd_reg         <= spq_cmd_t'(cmd);
            item_entry_reg.value <= item_value;
            item_entry_reg.prio  <= item_priority;
        end
        res_value_reg  <= res_value_next;
        res_prio_reg   <= res_prio_next;
        res_status_reg <= res_status_next;
        if (ctrl.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_prio_reg   <= res_prio_reg;
            out_status_reg <= res_status_reg;
            out_fill_reg   <= count_ext[FILL_W-1:0];
        end
    end

    assign out_value    = out_value_reg;
    assign out_priority = out_prio_reg;
    assign status       = out_status_reg;
    assign fill_count   = out_fill_reg;

endmodule

// ===== hdl/spq_ctrl.sv =====
// Controller: sequences insert shifts and pop scans, owns both handshakes.
// Depends on spq_pkg.
module spq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output spq_pkg::spq_ctrl_t ctrl,
    input  spq_pkg::spq_stat_t stat
);
    import spq_pkg::*;

    spq_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = S_START;
                end
            end
            S_START:
            begin
                ctrl.start = 1'b1;
                if (stat.is_insert)
                begin
                    if (stat.full)
                    begin
                        state_next = S_DONE;
                    end
                    else if (stat.empty)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        state_next = S_INS_CMP;
                    end
                end
                else
                begin
                    state_next = stat.empty ? S_DONE : S_SCAN;
                end
            end
            S_INS_CMP:
            begin
                ctrl.ins_step = 1'b1;
                if (!stat.ins_shift)
                begin
                    state_next = S_DONE;
                end
                else if (stat.ins_last)
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                ctrl.ins_put = 1'b1;
                state_next   = S_DONE;
            end
            S_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/sorted_priority_queue_top.sv =====
// Sorted priority queue top level: controller plus datapath over one entry RAM.
// One item at a time: the queue returns to idle after each result before it takes the
// next beat. Inserts and pops walk the store one entry a cycle.
// Reset (rst_n, async, low) clears the fill count and sets capacity_limit to 128;
// store contents stay undefined. Depends on spq_pkg, spq_ctrl, spq_datapath, spq_ram.
module sorted_priority_queue_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       cmd,
    input  logic signed [spq_pkg::VAL_W-1:0] item_value,
    input  logic [spq_pkg::PRI_W-1:0]        item_priority,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [spq_pkg::VAL_W-1:0] out_value,
    output logic [spq_pkg::PRI_W-1:0]        out_priority,
    output logic [1:0]                       status,
    output logic [spq_pkg::FILL_W-1:0]       fill_count,
    // capacity_limit write port
    input  logic                             cfg_we,
    input  logic [spq_pkg::CAP_W-1:0]        cfg_wdata
);
    import spq_pkg::*;

`include "sorted_priority_queue_top_defines.svh"

    spq_ctrl_t ctrl;
    spq_stat_t stat;

    // The controller only accepts a beat in idle; it walks the store one
    // entry per cycle and loads the result register once the old result
    // has left, so a waiting result holds back the next beat.
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    // The datapath holds the sorted store (head at address 0), the fill
    // count, the capacity register and the result registers. Insert shifts
    // lower-priority entries up from the tail; pops scan from the head and
    // close the gap behind the match in the same pass.
    spq_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .cmd           (cmd),
        .item_value    (item_value),
        .item_priority (item_priority),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .status        (status),
        .fill_count    (fill_count)
    );

    // Failed steps and inserts never carry an entry out
    `SPQ_CHECK_NOW(a_fail_zero, out_valid && (status != ST_OK), (out_value == '0) && (out_priority == '0), "failed step carries a nonzero entry")
    // Empty is only reported with nothing held
    `SPQ_CHECK_NOW(a_empty_fill, out_valid && (status == ST_EMPTY), fill_count == '0, "empty status with entries held")
    // At most one datapath command at a time
    `SPQ_CHECK_NOW(a_cmd_onehot, 1'b1, $onehot0(ctrl), "overlapping datapath commands")
    // One item in flight: no second beat right after a first
    `SPQ_CHECK_NEXT(a_one_item, in_valid && in_ready, !in_ready, "beat taken while busy")

endmodule
